[hw/rtl/rasr_pkg.sv]
// Package for the rational add/subtract/reduce block.
// Holds widths, shared types and the divider command struct. No dependencies.
package rasr_pkg;
  localparam int WIDTH = 32;
  localparam int NUM_W = 32;
  localparam int DEN_W = 31;
  localparam int WIDE_W = 64;

  // Largest negative magnitude and largest positive value of a WIDTH-bit result.
  localparam logic [WIDE_W-1:0] MAG_LIM = WIDE_W'(1) << (WIDTH - 1);
  localparam logic [WIDE_W-1:0] POS_LIM = MAG_LIM - WIDE_W'(1);

  typedef struct packed {
    logic               start;
    logic [WIDE_W-1:0]  dividend;
    logic [WIDE_W-1:0]  divisor;
  } div_cmd_t;

  typedef struct packed {
    logic               done;
    logic [WIDE_W-1:0]  quotient;
    logic [WIDE_W-1:0]  remainder;
  } div_rsp_t;
endpackage

[hw/rtl/rasr_if.sv]
// Valid/ready channel interfaces for the rational add/subtract block.
// Depends on rasr_pkg.
interface rasr_in_if import rasr_pkg::*; (input logic clk);
  logic              valid;
  logic              ready;
  logic              action;
  logic [NUM_W-1:0]  first_num;
  logic [DEN_W-1:0]  first_den;
  logic [NUM_W-1:0]  second_num;
  logic [DEN_W-1:0]  second_den;
  modport source(output valid, action, first_num, first_den, second_num, second_den,
                 input ready);
  modport sink(input valid, action, first_num, first_den, second_num, second_den,
               output ready);
endinterface

interface rasr_out_if import rasr_pkg::*; (input logic clk);
  logic              valid;
  logic              ready;
  logic [NUM_W-1:0]  result_num;
  logic [DEN_W-1:0]  result_den;
  logic              overflow;
  modport source(output valid, result_num, result_den, overflow, input ready);
  modport sink(input valid, result_num, result_den, overflow, output ready);
endinterface

[hw/rtl/rasr_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on rasr_pkg. Shared by every divide and remainder of the block.
module rasr_div import rasr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_cmd_t cmd,
  output div_rsp_t rsp
);
  logic [WIDE_W-1:0]  quo;
  logic [WIDE_W-1:0]  rem;
  logic [WIDE_W-1:0]  dvs;
  logic [6:0]         cnt;
  logic               busy;
  logic               done;
  logic [WIDE_W:0]    trial;
  logic [WIDE_W:0]    diff;

  assign trial = {rem, quo[WIDE_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start && !busy) begin
        busy <= 1'b1;
        quo  <= cmd.dividend;
        dvs  <= cmd.divisor;
        rem  <= '0;
        cnt  <= 7'(WIDE_W);
      end else if (busy) begin
        // shift in next dividend bit, subtract when it fits
        if (!diff[WIDE_W]) begin
          rem <= diff[WIDE_W-1:0];
          quo <= {quo[WIDE_W-2:0], 1'b1};
        end else begin
          rem <= trial[WIDE_W-1:0];
          quo <= {quo[WIDE_W-2:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, quo, rem};
endmodule

[hw/rtl/rational_add_sub_reduce.sv]
// Top level of the rational add/subtract/reduce block.
// Depends on rasr_pkg, rasr_if and rasr_div.
//
//  channel | dir | payload
//  in      | in  | action, first_num, first_den, second_num, second_den
//  out     | out | result_num, result_den, overflow
//
// Divides: every divide runs on the shared divider (start, quotient bits, done).
//   An item runs Euclid steps on the denominators and then on the result;
//   a zero result skips the second, a zero denominator goes straight out.
// Reset: rst is synchronous; the sequencer returns to idle, output empties.
// Stalls: in.ready is high only while idle; a finished result waits in the
//   last state only while the output register still holds an untaken result.
module rational_add_sub_reduce import rasr_pkg::*; (
  input  logic clk,
  input  logic rst,
  rasr_in_if.sink    in,
  rasr_out_if.source out
);
  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_G1    = 12'b000000000010,
    S_G1W   = 12'b000000000100,
    S_L1W   = 12'b000000001000,
    S_L2W   = 12'b000000010000,
    S_MUL   = 12'b000000100000,
    S_ADD   = 12'b000001000000,
    S_G2    = 12'b000010000000,
    S_G2W   = 12'b000100000000,
    S_R1W   = 12'b001000000000,
    S_R2W   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state;
  div_cmd_t cmd;
  div_rsp_t rsp;

  logic [DEN_W-1:0]  d1, d2;
  logic [NUM_W-1:0]  m1, m2;   // magnitudes, up to 2^31
  logic              s1, s2, sr;
  logic [WIDE_W-1:0] ga, gb, lcm, mag, k1, k2, p1, p2, rn;
  logic              start;
  logic              bad;      // zero denominator on the input
  logic              out_free;

  rasr_div u_div (.clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp));

  assign in.ready = (state == S_IDLE);
  assign out_free = !out.valid || out.ready;

  always_comb begin
    cmd.start    = start;
    cmd.dividend = ga;
    cmd.divisor  = gb;
    unique case (state)
      S_L1W, S_L2W: cmd.dividend = lcm;
      S_R2W:        cmd.dividend = lcm;
      default:      cmd.dividend = ga;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out.valid <= 1'b0;
      start <= 1'b0;
    end else begin
      start <= 1'b0;
      // load a result when the register is free, drop it after its transfer
      if (state == S_OUT && out_free) out.valid <= 1'b1;
      else if (out.ready) out.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in.valid && in.ready) begin
          d1 <= in.first_den;
          d2 <= in.second_den;
          s1 <= in.first_num[NUM_W-1];
          m1 <= in.first_num[NUM_W-1] ? (~in.first_num + 1'b1) : in.first_num;
          s2 <= in.second_num[NUM_W-1] ^ in.action;
          m2 <= in.second_num[NUM_W-1] ? (~in.second_num + 1'b1) : in.second_num;
          ga <= WIDE_W'(in.first_den);
          gb <= WIDE_W'(in.second_den);
          if (in.first_den == '0 || in.second_den == '0) begin
            bad <= 1'b1;
            state <= S_OUT;
          end else begin
            bad <= 1'b0;
            state <= S_G1;
          end
        end
        S_G1: begin
          // Euclid step: stop when divisor is zero
          if (gb == '0) begin
            // ga = gcd; lcm = (d1/g)*d2, first get d1/g
            lcm <= WIDE_W'(d1);
            gb <= ga;
            start <= 1'b1;
            state <= S_L1W;
          end else begin
            start <= 1'b1;
            state <= S_G1W;
          end
        end
        S_G1W: if (rsp.done) begin
          ga <= gb;
          gb <= rsp.remainder;
          state <= S_G1;
        end
        S_L1W: if (rsp.done) begin
          lcm <= rsp.quotient[DEN_W-1:0] * WIDE_W'(d2);
          k2 <= rsp.quotient;           // lcm/d2 = d1/g
          gb <= WIDE_W'(d1);
          state <= S_L2W;
          start <= 1'b1;
        end
        S_L2W: if (rsp.done) begin
          k1 <= rsp.quotient;           // lcm/d1
          state <= S_MUL;
        end
        S_MUL: begin
          p1 <= m1 * k1[NUM_W-1:0];
          p2 <= m2 * k2[NUM_W-1:0];
          state <= S_ADD;
        end
        S_ADD: begin
          if (s1 == s2) begin
            mag <= p1 + p2; sr <= s1;
          end else if (p1 >= p2) begin
            mag <= p1 - p2; sr <= s1;
          end else begin
            mag <= p2 - p1; sr <= s2;
          end
          state <= S_G2;
          ga <= '0;
        end
        S_G2: begin
          if (ga == '0) begin
            // zero sum skips the reduction and goes out as 0/1
            if (mag == '0) begin
              state <= S_OUT;
            end else begin
              ga <= mag;
              gb <= lcm;
            end
          end else if (gb == '0) begin
            gb <= ga;
            ga <= mag;
            start <= 1'b1;
            state <= S_R1W;
          end else begin
            start <= 1'b1;
            state <= S_G2W;
          end
        end
        S_G2W: if (rsp.done) begin
          ga <= gb;
          gb <= rsp.remainder;
          state <= S_G2;
        end
        S_R1W: if (rsp.done) begin
          rn <= rsp.quotient;
          start <= 1'b1;
          state <= S_R2W;
        end
        // the divider holds lcm/g as its quotient until the next start
        S_R2W: if (rsp.done) begin
          state <= S_OUT;
        end
        S_OUT: if (out_free) begin
          state <= S_IDLE;
          if (bad) begin
            out.result_num <= '0;
            out.result_den <= '0;
            out.overflow <= 1'b1;
          end else if (mag == '0) begin
            out.result_num <= '0;
            out.result_den <= DEN_W'(1);
            out.overflow <= 1'b0;
          end else if ((sr ? rn > MAG_LIM : rn > POS_LIM) || rsp.quotient > POS_LIM) begin
            out.result_num <= '0;
            out.result_den <= '0;
            out.overflow <= 1'b1;
          end else begin
            out.result_num <= sr ? (~rn[NUM_W-1:0] + 1'b1) : rn[NUM_W-1:0];
            out.result_den <= rsp.quotient[DEN_W-1:0];
            out.overflow <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in.ready |-> state == S_IDLE) else $error("ready outside idle");
  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.overflow) |-> (out.result_den == '0 && out.result_num == '0))
    else $error("overflow result not zero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> out.valid) else $error("result dropped");
  a_stable: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> ($stable(out.result_num) && $stable(out.result_den)
    && $stable(out.overflow))) else $error("result changed while waiting");
`endif
endmodule

[test/rasr_test_if.sv]
`timescale 1ns / 1ps
// Test-side note for the rational add/subtract testbench.
// The channel interfaces come from hw/rtl/rasr_if.sv; this file holds the
// fraction types: action, operation and result. Depends on rasr_pkg.
package rasr_test_pkg;
  import rasr_pkg::*;

  typedef enum logic {ACT_ADD = 1'b0, ACT_SUB = 1'b1} act_e;

  typedef struct packed {
    act_e              action;
    logic [NUM_W-1:0]  first_num;
    logic [DEN_W-1:0]  first_den;
    logic [NUM_W-1:0]  second_num;
    logic [DEN_W-1:0]  second_den;
  } frac_op_t;

  typedef struct packed {
    logic [NUM_W-1:0]  result_num;
    logic [DEN_W-1:0]  result_den;
    logic              overflow;
  } frac_res_t;
endpackage

[test/rational_add_sub_reduce_test.sv]
`timescale 1ns / 1ps
// Testbench for rational_add_sub_reduce: directed table, then random fractions.
// Depends on rasr_pkg, rasr_if (RTL) and rasr_test_pkg.
module rational_add_sub_reduce_test;
  import rasr_pkg::*;
  import rasr_test_pkg::*;

  localparam int N_RANDOM = 1600;
  localparam logic [NUM_W-1:0] NUM_MAX = 32'h7FFF_FFFF;
  localparam logic [NUM_W-1:0] NUM_MIN = 32'h8000_0000;
  localparam logic [DEN_W-1:0] DEN_MAX = 31'h7FFF_FFFF;

  logic clk;
  logic rst;

  rasr_in_if  in_ch(clk);
  rasr_out_if out_ch(clk);

  rational_add_sub_reduce dut (
    .clk(clk),
    .rst(rst),
    .in(in_ch.sink),
    .out(out_ch.source)
  );

  // Idle percentages of each side, changed per phase.
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned fail_count;

  frac_res_t expected_sums[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard limit: a run that has not finished by this timeout is reported as failed.
  initial begin
    #(64'd20 * 64'd100_000_000);
    $display("** rational_add_sub_reduce: FAILED **");
    $finish;
  end

  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Compute the reduced sum or difference of two fractions.
  function automatic frac_res_t reduce_sum(frac_op_t op);
    frac_res_t r;
    logic s1, s2, sr;
    logic [63:0] m1, m2, g, lcm, mag, rn, rd, lim;
    lim = 64'd1 << (WIDTH - 1);
    r = '0;
    if (op.first_den == 0 || op.second_den == 0) begin
      r.overflow = 1'b1;
      return r;
    end
    s1 = op.first_num[NUM_W-1];
    s2 = op.second_num[NUM_W-1];
    m1 = s1 ? 64'h1_0000_0000 - {32'd0, op.first_num} : {32'd0, op.first_num};
    m2 = s2 ? 64'h1_0000_0000 - {32'd0, op.second_num} : {32'd0, op.second_num};
    if (op.action == ACT_SUB) s2 = ~s2;
    g = gcd64(64'(op.first_den), 64'(op.second_den));
    lcm = (op.first_den / g) * op.second_den;
    m1 = m1 * (lcm / op.first_den);
    m2 = m2 * (lcm / op.second_den);
    if (s1 == s2) begin
      mag = m1 + m2;
      sr = s1;
    end else if (m1 >= m2) begin
      mag = m1 - m2;
      sr = s1;
    end else begin
      mag = m2 - m1;
      sr = s2;
    end
    if (mag == 0) begin
      r.result_den = 31'd1;
      return r;
    end
    g = gcd64(mag, lcm);
    rn = mag / g;
    rd = lcm / g;
    if ((sr ? rn > lim : rn > lim - 1) || rd > lim - 1) begin
      r.overflow = 1'b1;
      return r;
    end
    r.result_num = sr ? (32'd0 - rn[31:0]) : rn[31:0];
    r.result_den = rd[DEN_W-1:0];
    return r;
  endfunction

  // Drive one transfer; hold the payload until it is taken. Valid stays high
  // on return; idle cycles and wait_drained drop it.
  task automatic send_op(frac_op_t op);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= op.action;
    in_ch.first_num  <= op.first_num;
    in_ch.first_den  <= op.first_den;
    in_ch.second_num <= op.second_num;
    in_ch.second_den <= op.second_den;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid, let the predictor see the last transfer, then wait for results.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
  endtask

  // Random denominator: mostly small, sometimes full range, never zero.
  function automatic logic [DEN_W-1:0] rand_den();
    case ($urandom_range(3))
      0: return DEN_W'($urandom_range(1, 16));
      1: return DEN_W'($urandom_range(1, 1000));
      2: return DEN_W'($urandom_range(1, 65535));
      default: return DEN_W'(($urandom() & DEN_MAX) | 32'd1 << $urandom_range(30));
    endcase
  endfunction

  function automatic logic [NUM_W-1:0] rand_num();
    case ($urandom_range(3))
      0: return $urandom_range(0, 40) - 20;
      1: return $urandom_range(0, 2000) - 1000;
      default: return $urandom();
    endcase
  endfunction

  // Predict on acceptance at the input.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      expected_sums.push_back(reduce_sum({act_e'(in_ch.action), in_ch.first_num,
        in_ch.first_den, in_ch.second_num, in_ch.second_den}));
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    frac_res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_sums.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        want = expected_sums.pop_front();
        if (out_ch.result_num !== want.result_num) begin
          $error("result_num expected %0d got %0d", $signed(want.result_num),
                 $signed(out_ch.result_num));
          fail_count++;
        end
        if (out_ch.result_den !== want.result_den) begin
          $error("result_den expected %0d got %0d", want.result_den, out_ch.result_den);
          fail_count++;
        end
        if (out_ch.overflow !== want.overflow) begin
          $error("overflow expected %0b got %0b", want.overflow, out_ch.overflow);
          fail_count++;
        end
      end
    end
  end

  // Receiver stall: redraw ready every cycle.
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Directed table; rows with a typed result also check the predictor.
  typedef struct {
    frac_op_t  op;
    logic      has_want;
    frac_res_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(act_e a, logic [NUM_W-1:0] n1, logic [DEN_W-1:0] d1,
                         logic [NUM_W-1:0] n2, logic [DEN_W-1:0] d2,
                         logic has, logic [NUM_W-1:0] rn = 0,
                         logic [DEN_W-1:0] rd = 0, logic ov = 0);
    dir_row_t row;
    row.op = {a, n1, d1, n2, d2};
    row.has_want = has;
    row.want = {rn, rd, ov};
    dir_rows.push_back(row);
  endtask

  initial begin
    frac_op_t op;
    fail_count = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.first_num = '0;
    in_ch.first_den = 31'd1;
    in_ch.second_num = '0;
    in_ch.second_den = 31'd1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Zero result, simple sums, zero denominators, values and overflow at the extremes.
    add_row(ACT_ADD, 0, 1, 0, 1, 1, 0, 1, 0);
    add_row(ACT_ADD, 1, 2, 1, 3, 1, 5, 6, 0);
    add_row(ACT_SUB, 1, 2, 1, 3, 1, 1, 6, 0);
    add_row(ACT_SUB, 1, 3, 1, 2, 1, -1, 6, 0);
    add_row(ACT_SUB, 5, 7, 5, 7, 1, 0, 1, 0);
    add_row(ACT_ADD, 3, 4, -3, 4, 1, 0, 1, 0);
    add_row(ACT_ADD, 2, 4, 2, 4, 1, 1, 1, 0);
    add_row(ACT_ADD, 1, 0, 1, 1, 1, 0, 0, 1);
    add_row(ACT_SUB, 1, 1, 1, 0, 1, 0, 0, 1);
    add_row(ACT_ADD, NUM_MAX, 1, 1, 1, 1, 0, 0, 1);
    add_row(ACT_ADD, NUM_MAX, 1, 0, 1, 1, NUM_MAX, 1, 0);
    add_row(ACT_ADD, NUM_MIN, 1, 0, 1, 1, NUM_MIN, 1, 0);
    add_row(ACT_SUB, NUM_MIN, 1, 1, 1, 1, 0, 0, 1);
    add_row(ACT_SUB, 0, 1, NUM_MIN, 1, 1, 0, 0, 1);
    add_row(ACT_ADD, NUM_MIN, 1, NUM_MIN, 1, 1, 0, 0, 1);
    add_row(ACT_SUB, NUM_MIN, 1, NUM_MIN, 1, 1, 0, 1, 0);
    add_row(ACT_ADD, 1, DEN_MAX, 1, DEN_MAX - 1, 1, 0, 0, 1);
    add_row(ACT_ADD, 1, DEN_MAX, 0, DEN_MAX, 1, 1, DEN_MAX, 0);
    add_row(ACT_ADD, NUM_MAX, DEN_MAX, NUM_MIN, DEN_MAX, 0);
    add_row(ACT_SUB, NUM_MIN, DEN_MAX, NUM_MAX, 1, 0);
    add_row(ACT_ADD, -7, 12, 5, 18, 0);
    add_row(ACT_SUB, 32'h5555_5555, 31'h2AAA_AAAA, 32'hAAAA_AAAA, 31'h5555_5555, 0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_want && reduce_sum(dir_rows[i].op) !== dir_rows[i].want) begin
        $error("table row %0d: predictor disagrees with typed result", i);
        fail_count++;
      end
      send_op(dir_rows[i].op);
    end
    wait_drained();

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 52; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 52; end
        default: begin src_idle_pct = 8; snk_stall_pct = 8; end
      endcase
      for (int k = 0; k < N_RANDOM / 4; k++) begin
        op.action = act_e'($urandom_range(1));
        op.first_num = rand_num();
        op.second_num = rand_num();
        op.first_den = rand_den();
        op.second_den = ($urandom_range(3) == 0) ? op.first_den : rand_den();
        if ($urandom_range(199) == 0) op.first_den = 0;
        if ($urandom_range(199) == 0) op.second_den = 0;
        // Once per phase, hold off until the block has drained.
        if (k == 100) wait_drained();
        send_op(op);
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (expected_sums.size() != 0) begin
      $error("results missing at end of run");
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("** rational_add_sub_reduce: PASSED **");
    end else begin
      $display("** rational_add_sub_reduce: FAILED **");
    end
    $finish;
  end
endmodule

[files.f]
hw/rtl/rasr_pkg.sv
hw/rtl/rasr_if.sv
hw/rtl/rasr_div.sv
hw/rtl/rational_add_sub_reduce.sv
test/rasr_test_if.sv
test/rational_add_sub_reduce_test.sv
